// File: rtl/assert_macros.svh
// Assertion helper macros for the axis homing and limit controller.
// No dependencies; taken in by the top level with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// File: rtl/ahlc_pkg.sv
// Shared types and constants for the axis homing and limit controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ahlc_pkg;

   localparam int unsigned FULL_SCALE_MV_DEF = 24000;
   localparam int unsigned PWM_FULL          = 32767;
   localparam int unsigned NUM_W             = 32;
   localparam int unsigned CSR_IDX_W         = 2;
   localparam int unsigned CSR_DATA_W        = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_DIRECTION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_SWITCH    = 2'd2;

   typedef struct packed {
      logic [14:0] max_speed;
      logic        ref_direction;
      logic        ref_switch_select;
   } cfg_type;

   typedef struct packed {
      logic               mode_write;
      logic [1:0]         mode_request;
      logic               end_switch_a;
      logic               end_switch_b;
      logic               force_switch_a;
      logic               force_switch_b;
      logic signed [15:0] user_speed;
   } scan_type;

   typedef struct packed {
      logic signed [15:0] set_speed;
      logic               reset_error;
      logic               reset_counter;
      logic               referenced;
      logic [1:0]         mode;
   } ctrl_out_type;

endpackage

// File: rtl/axis_homing_limit_controller_top.sv
// Axis homing and limit controller: one control scan in, one result out.
// Channels: req_* scans in (valid/stall), rsp_* results out (valid/stall),
// csr_* register writes (valid/ready, ready always high).
// Path: a transferred scan is registered in stage 1, stage 2 and the output
// register in turn; rsp_valid rises once it reaches the output register.
// Throughput: one scan per cycle unless rsp_stall holds the pipeline. The mode
// sequencer updates in the accept cycle; the PWM and feedback scaling run in a
// three-register pipeline (input products, reciprocal estimate, corrected result).
// Stall: each stage holds while the next is full and held; req_stall rises
// only when all three stages are full and rsp_stall is high.
// Reset: synchronous, clears mode to stop, the referenced flag, setpoint,
// pulses, registers and all pipeline valid bits. No clearing pass.
// The user must write registers only while the block is idle; the block does not enforce it.
// Depends on ahlc_pkg, ahlc_ctrl, ahlc_scale and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module axis_homing_limit_controller_top import ahlc_pkg::*; #(
   parameter int unsigned FULL_SCALE_MV = FULL_SCALE_MV_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode_write,
   input  logic [1:0]            req_mode_request,
   input  logic                  req_end_switch_a,
   input  logic                  req_end_switch_b,
   input  logic                  req_force_switch_a,
   input  logic                  req_force_switch_b,
   input  logic signed [15:0]    req_user_speed,
   input  logic signed [15:0]    req_drive_millivolts,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_set_speed,
   output logic signed [15:0]    rsp_pwm_value,
   output logic signed [15:0]    rsp_feedback_speed,
   output logic                  rsp_reset_error,
   output logic                  rsp_reset_counter,
   output logic                  rsp_is_referenced,
   output logic [1:0]            rsp_current_mode,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type          cfg_ff;
   scan_type         scan;
   ctrl_out_type     ctrl_state, ctrl_s2_ff, ctrl_s3_ff;
   logic             s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic             s1_free, s2_free, s3_free;
   logic             accept, ld2, ld3;
   logic [15:0]      mag;
   logic [NUM_W-1:0] pwm_num, fbk_num;
   logic [NUM_W-1:0] pwm_num_ff, fbk_num_ff;
   logic             neg_ff;
   logic             pwm_zero;

   // flow control
   assign s3_free   = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign accept    = req_valid && s1_free;
   assign ld2       = s1_valid_ff && s2_free;
   assign ld3       = s2_valid_ff && s3_free;
   assign req_stall = !s1_free;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         s1_valid_ff  <= accept || (s1_valid_ff && !s2_free);
         s2_valid_ff  <= ld2 || (s2_valid_ff && !s3_free);
         rsp_valid_ff <= ld3 || (rsp_valid_ff && rsp_stall);
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_SPEED:     cfg_ff.max_speed         <= csr_data;
               CSR_REF_DIRECTION: cfg_ff.ref_direction     <= csr_data[0];
               CSR_REF_SWITCH:    cfg_ff.ref_switch_select <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // scan input and scaling numerators
   always_comb begin
      scan = '{mode_write:     req_mode_write,
               mode_request:   req_mode_request,
               end_switch_a:   req_end_switch_a,
               end_switch_b:   req_end_switch_b,
               force_switch_a: req_force_switch_a,
               force_switch_b: req_force_switch_b,
               user_speed:     req_user_speed};
      mag      = req_drive_millivolts[15] ? 16'(-req_drive_millivolts)
                                          : 16'(req_drive_millivolts);
      pwm_num  = NUM_W'(mag) * NUM_W'(2 * PWM_FULL) + NUM_W'(FULL_SCALE_MV);
      fbk_num  = NUM_W'(mag) * NUM_W'(cfg_ff.max_speed);
      pwm_zero = pwm_num < NUM_W'(2 * FULL_SCALE_MV);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pwm_num_ff <= pwm_num;
         fbk_num_ff <= fbk_num;
         neg_ff     <= req_drive_millivolts[15];
      end
      if (ld2) begin
         ctrl_s2_ff <= ctrl_state;
      end
      if (ld3) begin
         ctrl_s3_ff <= ctrl_s2_ff;
      end
   end

   ahlc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .scan     (scan),
      .pwm_zero (pwm_zero),
      .cfg      (cfg_ff),
      .state    (ctrl_state)
   );

   ahlc_scale #(.DIVISOR(2 * FULL_SCALE_MV)) u_pwm_scale (
      .clock    (clock),
      .load_est (ld2),
      .load_out (ld3),
      .num      (pwm_num_ff),
      .neg      (neg_ff),
      .value    (rsp_pwm_value)
   );

   ahlc_scale #(.DIVISOR(FULL_SCALE_MV)) u_fbk_scale (
      .clock    (clock),
      .load_est (ld2),
      .load_out (ld3),
      .num      (fbk_num_ff),
      .neg      (neg_ff),
      .value    (rsp_feedback_speed)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_set_speed     = ctrl_s3_ff.set_speed;
   assign rsp_reset_error   = ctrl_s3_ff.reset_error;
   assign rsp_reset_counter = ctrl_s3_ff.reset_counter;
   assign rsp_is_referenced = ctrl_s3_ff.referenced;
   assign rsp_current_mode  = ctrl_s3_ff.mode;

   `AST_IMPL(a_cnt_ref, clock, reset, rsp_valid && rsp_reset_counter, rsp_is_referenced)
   `AST_IMPL(a_cnt_speed, clock, reset, rsp_valid && rsp_reset_counter, rsp_set_speed == 16'sd0)
   `AST_NEXT(a_ref_sticky, clock, reset, ctrl_state.referenced, ctrl_state.referenced)
   `AST_NEXT(a_s1_fill, clock, reset, accept, s1_valid_ff)

endmodule

// File: rtl/ahlc_ctrl.sv
// Mode sequencer for the axis controller: stop / homing / moving, referenced flag,
// speed setpoint and pulse outputs. Depends on ahlc_pkg.
`timescale 1ns / 1ps

module ahlc_ctrl import ahlc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  scan_type     scan,
   input  logic         pwm_zero,
   input  cfg_type      cfg,
   output ctrl_out_type state
);

   typedef enum logic [1:0] {
      MODE_STOP   = 2'd0,
      MODE_HOMING = 2'd1,
      MODE_MOVING = 2'd2
   } mode_type;

   mode_type           mode_ff, mode_in, mode_sel;
   logic               referenced_ff, referenced_in;
   logic               pwm_zero_ff;
   logic signed [15:0] speed_ff, speed_in;
   logic               err_ff, err_in;
   logic               cnt_ff, cnt_in;
   logic               side_a, side_b, ref_trip, far_trip;
   logic               toward, away, req_ok;
   logic signed [15:0] homing_speed;

   always_comb begin
      side_a   = scan.end_switch_a | scan.force_switch_a;
      side_b   = scan.end_switch_b | scan.force_switch_b;
      ref_trip = cfg.ref_switch_select ? side_b : side_a;
      far_trip = cfg.ref_switch_select ? side_a : side_b;
      toward   = cfg.ref_direction ? (scan.user_speed > 16'sd0) : (scan.user_speed < 16'sd0);
      away     = cfg.ref_direction ? (scan.user_speed < 16'sd0) : (scan.user_speed > 16'sd0);
      homing_speed = cfg.ref_direction ? $signed({1'b0, cfg.max_speed})
                                       : -$signed({1'b0, cfg.max_speed});
      req_ok = (scan.mode_request == MODE_STOP) || (scan.mode_request == MODE_HOMING) ||
               (scan.mode_request == MODE_MOVING);
      mode_sel = (scan.mode_write && req_ok) ? mode_type'(scan.mode_request) : mode_ff;

      mode_in       = mode_sel;
      referenced_in = referenced_ff;
      speed_in      = speed_ff;
      err_in        = 1'b0;
      cnt_in        = 1'b0;
      case (mode_sel)
         MODE_STOP: begin
            speed_in = 16'sd0;
            err_in   = scan.end_switch_a | scan.end_switch_b;
         end
         MODE_HOMING: begin
            if (!referenced_ff) begin
               speed_in = homing_speed;
               if (ref_trip) begin
                  speed_in = 16'sd0;
                  if (pwm_zero_ff) begin
                     referenced_in = 1'b1;
                     cnt_in        = 1'b1;
                     mode_in       = MODE_STOP;
                  end
               end
            end else begin
               mode_in = mode_ff;
            end
         end
         MODE_MOVING: begin
            if (referenced_ff) begin
               speed_in = scan.user_speed;
               if ((ref_trip && toward) || (far_trip && away)) begin
                  speed_in = 16'sd0;
                  mode_in  = MODE_STOP;
               end
            end else begin
               mode_in = mode_ff;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_STOP;
         referenced_ff <= 1'b0;
         pwm_zero_ff   <= 1'b1;
         speed_ff      <= 16'sd0;
         err_ff        <= 1'b0;
         cnt_ff        <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         referenced_ff <= referenced_in;
         pwm_zero_ff   <= pwm_zero;
         speed_ff      <= speed_in;
         err_ff        <= err_in;
         cnt_ff        <= cnt_in;
      end
   end

   assign state = '{set_speed:     speed_ff,
                    reset_error:   err_ff,
                    reset_counter: cnt_ff,
                    referenced:    referenced_ff,
                    mode:          mode_ff};

endmodule

// File: rtl/ahlc_scale.sv
// Two-stage divide-by-constant unit: reciprocal estimate, then one remainder
// correction, saturation to +-32767 and sign. Depends on ahlc_pkg.
`timescale 1ns / 1ps

module ahlc_scale import ahlc_pkg::*; #(
   parameter int unsigned DIVISOR = FULL_SCALE_MV_DEF
) (
   input  logic               clock,
   input  logic               load_est,
   input  logic               load_out,
   input  logic [NUM_W-1:0]   num,
   input  logic               neg,
   output logic signed [15:0] value
);

   localparam int unsigned   RECIP_SHIFT = NUM_W;
   localparam logic [63:0]   RECIP64     = (64'd1 << RECIP_SHIFT) / 64'(DIVISOR);
   localparam logic [NUM_W-1:0] RECIP    = RECIP64[NUM_W-1:0];
   localparam logic [63:0]   SAT_LIMIT   = 64'(PWM_FULL + 1) * 64'(DIVISOR);

   logic [2*NUM_W-1:0] prod;
   logic [15:0]        est_ff;
   logic [NUM_W-1:0]   num_ff;
   logic               sat_ff;
   logic               neg_ff;
   logic [47:0]        back;
   logic [47:0]        rem;
   logic [15:0]        quot;
   logic [15:0]        mag;
   logic signed [15:0] value_ff, value_in;

   assign prod = num * RECIP;

   always_ff @(posedge clock) begin
      if (load_est) begin
         est_ff <= prod[RECIP_SHIFT +: 16];
         num_ff <= num;
         sat_ff <= (64'(num) >= SAT_LIMIT);
         neg_ff <= neg;
      end
   end

   always_comb begin
      back     = 48'(est_ff) * 48'(DIVISOR);
      rem      = 48'(num_ff) - back;
      quot     = est_ff + 16'(rem >= 48'(DIVISOR));
      mag      = sat_ff ? 16'(PWM_FULL) : quot;
      value_in = neg_ff ? -$signed(mag) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule
